@@ design/gha_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types, constants and helpers for the gas and heat alarm controller.
// ----------------------------------------------------------------------------
package gha_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 14;
	localparam int unsigned COUNT_W     = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_GAS_THRESHOLD  = 2'd0,
		CFG_TEMP_THRESHOLD = 2'd1,
		CFG_DEBOUNCE_TICKS = 2'd2,
		CFG_BLINK_TICKS    = 2'd3
	} cfg_index_t;

	localparam logic [2:0] REASON_NORMAL = 3'd0;
	localparam logic [2:0] REASON_GAS    = 3'd1;
	localparam logic [2:0] REASON_HEAT   = 3'd2;
	localparam logic [2:0] REASON_BOTH   = 3'd3;
	localparam logic [2:0] REASON_MANUAL = 3'd4;

	localparam logic signed [11:0] TEMP_MIN = -12'sd200;
	localparam logic signed [11:0] TEMP_MAX = 12'sd600;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef struct packed {
		logic        [9:0]  gas_threshold;
		logic signed [10:0] temp_threshold;
		logic        [13:0] debounce_ticks;
		logic        [13:0] blink_ticks;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		gas_threshold:  10'd400,
		temp_threshold: 11'sd400,
		debounce_ticks: 14'd50,
		blink_ticks:    14'd200
	};

	typedef struct packed {
		logic               manual;
		logic               alarm;
		logic               prev_level;
		logic               stable_level;
		logic [COUNT_W-1:0] debounce_count;
		logic [COUNT_W-1:0] blink_count;
		logic               blink_phase;
		logic               led;
		logic               fan;
		logic        [9:0]  gas_value;
		logic signed [10:0] temp_value;
	} state_t;

	localparam state_t STATE_RESET = '{
		manual:         1'b0,
		alarm:          1'b0,
		prev_level:     1'b1,
		stable_level:   1'b1,
		debounce_count: '0,
		blink_count:    '0,
		blink_phase:    1'b0,
		led:            1'b0,
		fan:            1'b0,
		gas_value:      '0,
		temp_value:     '0
	};

	typedef struct packed {
		logic        button_level;
		logic [9:0]  gas_sample;
		logic [11:0] temperature_tenths;
		logic        temperature_valid;
	} item_t;

	typedef struct packed {
		logic       alarm_active;
		logic       manual_emergency;
		logic       led_on;
		logic       beep_start;
		logic       fan_on;
		logic [2:0] reason_code;
	} result_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		return (c == COUNT_MAX) ? c : c + {{(COUNT_W-1){1'b0}}, 1'b1};
	endfunction

endpackage

@@ design/gas_heat_alarm_controller_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_heat_alarm_controller_unit
// Millisecond-tick alarm controller with button debounce, gas and heat
// thresholds, fan control and LED blink with beep pulse.
// ----------------------------------------------------------------------------
// an item passes the input register and then the result register, from which its result is offered
// throughput: one item per cycle, limited only by the output stall
// the input register and the result register let the next item in while a
// result waits; state is updated as an item moves into the result register
// reset clears the tick state and loads the default thresholds at once
module gas_heat_alarm_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        button_level,
	input  logic [9:0]  gas_sample,
	input  logic signed [11:0] temperature_tenths,
	input  logic        temperature_valid,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        alarm_active,
	output logic        manual_emergency,
	output logic        led_on,
	output logic        beep_start,
	output logic        fan_on,
	output logic [2:0]  reason_code,
	input  logic        cfg_we,
	input  logic [gha_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gha_pkg::CFG_DATA_W-1:0]  cfg_data
);

	gha_pkg::cfg_t    cfg_q;
	gha_pkg::state_t  state_q;
	gha_pkg::state_t  state_nxt;
	gha_pkg::item_t   item_s1;
	gha_pkg::result_t res_nxt;
	gha_pkg::result_t res_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic             adv_s1;
	logic             s2_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= gha_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (gha_pkg::cfg_index_t'(cfg_index))
				gha_pkg::CFG_GAS_THRESHOLD:  cfg_q.gas_threshold  <= cfg_data[9:0];
				gha_pkg::CFG_TEMP_THRESHOLD: cfg_q.temp_threshold <= cfg_data[10:0];
				gha_pkg::CFG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data[13:0];
				gha_pkg::CFG_BLINK_TICKS:    cfg_q.blink_ticks    <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	assign s2_free  = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{
				button_level:       button_level,
				gas_sample:         gas_sample,
				temperature_tenths: temperature_tenths,
				temperature_valid:  temperature_valid
			};
		end
	end

	gha_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// tick state moves on as each item enters the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gha_pkg::STATE_RESET;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_nxt;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid        = valid_s2;
	assign alarm_active     = res_s2.alarm_active;
	assign manual_emergency = res_s2.manual_emergency;
	assign led_on           = res_s2.led_on;
	assign beep_start       = res_s2.beep_start;
	assign fan_on           = res_s2.fan_on;
	assign reason_code      = res_s2.reason_code;

`ifndef NO_ASSERTIONS
	a_reason_manual: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (manual_emergency == (reason_code == gha_pkg::REASON_MANUAL)))
		else $error("reason code disagrees with manual emergency");

	a_led_needs_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && led_on |-> alarm_active)
		else $error("led lit without alarm");

	a_beep_with_led: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beep_start |-> led_on)
		else $error("beep without led turn-on");

	a_fan_heat_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !manual_emergency |-> (fan_on == (reason_code == gha_pkg::REASON_HEAT)))
		else $error("fan level disagrees with heat without gas");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with no blocked item");
`endif

endmodule

@@ design/gha_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_step
// Next-state and result logic for one tick: debounce, sensor check, blinking.
// ----------------------------------------------------------------------------
module gha_step (
	input  gha_pkg::cfg_t    cfg,
	input  gha_pkg::state_t  cur,
	input  gha_pkg::item_t   item,
	output gha_pkg::state_t  nxt,
	output gha_pkg::result_t res
);

	always_comb begin
		gha_pkg::state_t s;
		logic gas_hi;
		logic temp_hi;
		logic beep;
		logic temp_bad;

		s    = cur;
		beep = 1'b0;

		// button debounce
		if (item.button_level != cur.prev_level) begin
			s.debounce_count = '0;
		end else begin
			s.debounce_count = gha_pkg::sat_inc(cur.debounce_count);
		end
		if (s.debounce_count > {2'b00, cfg.debounce_ticks}
				&& item.button_level != cur.stable_level) begin
			s.stable_level = item.button_level;
			if (!item.button_level) begin
				s.manual = !cur.manual;
				s.alarm  = s.manual;
				if (!s.manual) begin
					s.led = 1'b0;
				end
			end
		end
		s.prev_level = item.button_level;

		// sensors, frozen during manual emergency
		temp_bad = !item.temperature_valid
			|| $signed(item.temperature_tenths) < gha_pkg::TEMP_MIN
			|| $signed(item.temperature_tenths) > gha_pkg::TEMP_MAX;
		if (!s.manual) begin
			s.gas_value = item.gas_sample;
			if (!temp_bad) begin
				s.temp_value = item.temperature_tenths[10:0];
			end
		end
		gas_hi  = s.gas_value > cfg.gas_threshold;
		temp_hi = $signed(s.temp_value) > $signed(cfg.temp_threshold);
		if (!s.manual) begin
			s.fan = temp_hi && !gas_hi;
			if (gas_hi || temp_hi) begin
				s.alarm = 1'b1;
			end else begin
				if (s.alarm) begin
					s.led = 1'b0;
				end
				s.alarm = 1'b0;
			end
		end

		// blinking
		s.blink_count = gha_pkg::sat_inc(cur.blink_count);
		if (s.alarm && s.blink_count > {2'b00, cfg.blink_ticks}) begin
			s.blink_phase = !cur.blink_phase;
			s.led         = s.blink_phase;
			beep          = s.blink_phase;
			s.blink_count = '0;
		end

		nxt                  = s;
		res.alarm_active     = s.alarm;
		res.manual_emergency = s.manual;
		res.led_on           = s.led;
		res.beep_start       = beep;
		res.fan_on           = s.fan;
		res.reason_code      = s.manual ? gha_pkg::REASON_MANUAL
			: {1'b0, temp_hi, gas_hi};
	end

endmodule

@@ tb/tb_gas_heat_alarm_controller_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gas_heat_alarm_controller_unit
// Self-checking bench for the gas and heat alarm controller. Ticks are queued
// by the stimulus process, handed over by a clocked driver and predicted at
// the moment of transfer. A clocked monitor checks each result transfer,
// field by field, against the oldest prediction. Both sides idle at random
// and the receiver holds off once for a long stretch to back up the block.
// ----------------------------------------------------------------------------
module tb_gas_heat_alarm_controller_unit;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic               lvl;
		logic        [9:0]  gas;
		logic signed [11:0] temp;
		logic               temp_ok;
	} tick_t;

	typedef struct packed {
		logic       alarm;
		logic       manual;
		logic       led;
		logic       beep;
		logic       fan;
		logic [2:0] reason;
	} alarm_out_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               button_level = 1'b1;
	logic        [9:0]  gas_sample = '0;
	logic signed [11:0] temperature_tenths = '0;
	logic               temperature_valid = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               alarm_active;
	logic               manual_emergency;
	logic               led_on;
	logic               beep_start;
	logic               fan_on;
	logic [2:0]         reason_code;
	logic               cfg_we = 1'b0;
	gha_pkg::cfg_index_t cfg_index = gha_pkg::CFG_GAS_THRESHOLD;
	logic [gha_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	gas_heat_alarm_controller_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.button_level     (button_level),
		.gas_sample       (gas_sample),
		.temperature_tenths(temperature_tenths),
		.temperature_valid(temperature_valid),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.alarm_active     (alarm_active),
		.manual_emergency (manual_emergency),
		.led_on           (led_on),
		.beep_start       (beep_start),
		.fan_on           (fan_on),
		.reason_code      (reason_code),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #10 clk = ~clk;

	// controller mirror: thresholds and tick state
	logic        [9:0]  thr_gas = 10'd400;
	logic signed [10:0] thr_temp = 11'sd400;
	logic        [13:0] deb_ticks = 14'd50;
	logic        [13:0] blink_ticks = 14'd200;

	logic               man_q = 1'b0;
	logic               alarm_q = 1'b0;
	logic               prev_lvl = 1'b1;
	logic               stable_lvl = 1'b1;
	logic [gha_pkg::COUNT_W-1:0] deb_cnt = '0;
	logic [gha_pkg::COUNT_W-1:0] blink_cnt = '0;
	logic               phase_q = 1'b0;
	logic               led_q = 1'b0;
	logic               fan_q = 1'b0;
	logic        [9:0]  gas_q = '0;
	logic signed [10:0] temp_q = '0;

	tick_t      tick_queue[$];
	alarm_out_t due_outputs[$];
	logic       held = 1'b0;
	logic       steady = 1'b0;
	int         queued = 0;
	int         results_seen = 0;
	int         fault_count = 0;
	int         idle_cycles = 0;
	int         hold_left = 0;
	logic       pressure_done = 1'b0;

	function automatic alarm_out_t advance_controller(input tick_t t);
		logic signed [11:0] tv;
		logic gas_hi;
		logic temp_hi;
		alarm_out_t r;
		tv = $signed(t.temp);
		r.beep = 1'b0;

		if (t.lvl != prev_lvl)
			deb_cnt = '0;
		else if (deb_cnt != gha_pkg::COUNT_MAX)
			deb_cnt = deb_cnt + 1'b1;
		if (deb_cnt > deb_ticks && t.lvl != stable_lvl) begin
			stable_lvl = t.lvl;
			if (!stable_lvl) begin
				man_q = !man_q;
				alarm_q = man_q;
				if (!man_q)
					led_q = 1'b0;
			end
		end
		prev_lvl = t.lvl;

		// sensors are frozen while the manual emergency is on
		if (!man_q) begin
			gas_q = t.gas;
			if (t.temp_ok && tv >= -200 && tv <= 600)
				temp_q = tv[10:0];
			else if (temp_q < -200)
				temp_q = -11'sd200;
			else if (temp_q > 600)
				temp_q = 11'sd600;
			gas_hi = gas_q > thr_gas;
			temp_hi = temp_q > thr_temp;
			fan_q = temp_hi && !gas_hi;
			if (gas_hi || temp_hi) begin
				alarm_q = 1'b1;
			end else begin
				if (alarm_q)
					led_q = 1'b0;
				alarm_q = 1'b0;
			end
		end

		if (blink_cnt != gha_pkg::COUNT_MAX)
			blink_cnt = blink_cnt + 1'b1;
		if (alarm_q && blink_cnt > blink_ticks) begin
			phase_q = !phase_q;
			led_q = phase_q;
			r.beep = phase_q;
			blink_cnt = '0;
		end

		gas_hi = gas_q > thr_gas;
		temp_hi = temp_q > thr_temp;
		if (man_q)
			r.reason = gha_pkg::REASON_MANUAL;
		else if (gas_hi && temp_hi)
			r.reason = gha_pkg::REASON_BOTH;
		else if (gas_hi)
			r.reason = gha_pkg::REASON_GAS;
		else if (temp_hi)
			r.reason = gha_pkg::REASON_HEAT;
		else
			r.reason = gha_pkg::REASON_NORMAL;
		r.alarm = alarm_q;
		r.manual = man_q;
		r.led = led_q;
		r.fan = fan_q;
		return r;
	endfunction

	// driver: a held tick stays on the pins until its transfer
	always @(posedge clk) begin
		tick_t t;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				t.lvl = button_level;
				t.gas = gas_sample;
				t.temp = temperature_tenths;
				t.temp_ok = temperature_valid;
				due_outputs.push_back(advance_controller(t));
				held = 1'b0;
			end
			if (!in_valid || !in_stall) begin
				if (tick_queue.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
					t = tick_queue.pop_front();
					held = 1'b1;
					in_valid <= 1'b1;
					button_level <= t.lvl;
					gas_sample <= t.gas;
					temperature_tenths <= t.temp;
					temperature_valid <= t.temp_ok;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with one long hold-off to fill the block
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (!pressure_done && results_seen >= 150) begin
			pressure_done = 1'b1;
			hold_left = 80;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !steady && $urandom_range(99) < 19;
		end
	end

	always @(posedge clk) begin
		alarm_out_t got;
		alarm_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen = results_seen + 1;
			got = '{alarm_active, manual_emergency, led_on, beep_start, fan_on, reason_code};
			if (due_outputs.size() == 0) begin
				fault_count = fault_count + 1;
				if (fault_count <= REPORT_LIMIT)
					$display("unexpected result transfer at %0t", $realtime);
			end else begin
				want = due_outputs.pop_front();
				if (got.alarm !== want.alarm || got.manual !== want.manual ||
				    got.led !== want.led || got.beep !== want.beep ||
				    got.fan !== want.fan || got.reason !== want.reason) begin
					fault_count = fault_count + 1;
					if (fault_count <= REPORT_LIMIT)
						$display({"mismatch at %0t: expected alarm=%0d manual=%0d led=%0d ",
							"beep=%0d fan=%0d reason=%0d, got alarm=%0d manual=%0d led=%0d ",
							"beep=%0d fan=%0d reason=%0d"}, $realtime,
							want.alarm, want.manual, want.led, want.beep, want.fan,
							want.reason, got.alarm, got.manual, got.led, got.beep,
							got.fan, got.reason);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic push_tick(input logic lvl, input int gas, input int temp, input logic ok);
		tick_t t;
		t.lvl = lvl;
		t.gas = gas[9:0];
		t.temp = temp[11:0];
		t.temp_ok = ok;
		tick_queue.push_back(t);
		queued = queued + 1;
	endtask

	// sensor values mostly close to the thresholds, some anywhere in range, some temperatures out of range or invalid
	task automatic push_random_tick(input logic lvl);
		int g;
		int t;
		logic ok;
		if ($urandom_range(3) == 0)
			g = $urandom_range(1023);
		else
			g = int'(thr_gas) + int'($urandom_range(16)) - 8;
		if (g < 0) g = 0;
		if (g > 1023) g = 1023;
		ok = 1'b1;
		case ($urandom_range(7))
			0: t = int'($urandom_range(1650)) - 400;
			1: begin
				t = int'($urandom_range(800)) - 200;
				ok = 1'b0;
			end
			default: t = int'(thr_temp) + int'($urandom_range(40)) - 20;
		endcase
		if (t < -400) t = -400;
		if (t > 1250) t = 1250;
		push_tick(lvl, g, t, ok);
	endtask

	task automatic add_random(input int n);
		int stop;
		int k;
		int hold;
		logic lvl;
		stop = queued + n;
		lvl = 1'b1;
		while (queued < stop) begin
			k = $urandom_range(9);
			if (k < 3 && deb_ticks <= 100) begin
				// press and release, each just short of or past the debounce time
				hold = int'(deb_ticks) + int'($urandom_range(1, 4));
				repeat (hold) push_random_tick(1'b0);
				hold = int'(deb_ticks) + int'($urandom_range(1, 4));
				repeat (hold) push_random_tick(1'b1);
				lvl = 1'b1;
			end else if (k == 3) begin
				repeat ($urandom_range(1, 6)) begin
					lvl = 1'($urandom_range(1));
					push_random_tick(lvl);
				end
			end else begin
				repeat ($urandom_range(4, 30)) push_random_tick(lvl);
			end
		end
	endtask

	task automatic write_reg(input gha_pkg::cfg_index_t idx,
			input logic [gha_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			gha_pkg::CFG_GAS_THRESHOLD:  thr_gas = data[9:0];
			gha_pkg::CFG_TEMP_THRESHOLD: thr_temp = data[10:0];
			gha_pkg::CFG_DEBOUNCE_TICKS: deb_ticks = data;
			default:                     blink_ticks = data;
		endcase
	endtask

	// unused upper data bits carry junk, the block keeps only the field
	task automatic set_config(input int g, input int t, input int d, input int b);
		logic [3:0] junk;
		junk = 4'($urandom);
		write_reg(gha_pkg::CFG_GAS_THRESHOLD, {junk, g[9:0]});
		junk = 4'($urandom);
		write_reg(gha_pkg::CFG_TEMP_THRESHOLD, {junk[2:0], t[10:0]});
		write_reg(gha_pkg::CFG_DEBOUNCE_TICKS, d[13:0]);
		write_reg(gha_pkg::CFG_BLINK_TICKS, b[13:0]);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle;
		while (tick_queue.size() != 0 || held || due_outputs.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic run_phase(input int g, input int t, input int d, input int b, input int n);
		wait_idle();
		set_config(g, t, d, b);
		add_random(n);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: boundaries, both alarms, bad temperatures, a glitch
		push_tick(1'b1, 0, 0, 1'b1);
		push_tick(1'b1, 400, 400, 1'b1);
		push_tick(1'b1, 401, 0, 1'b1);
		push_tick(1'b1, 1023, 401, 1'b1);
		push_tick(1'b1, 0, 401, 1'b1);
		push_tick(1'b1, 0, 1250, 1'b1);
		push_tick(1'b1, 0, -400, 1'b1);
		push_tick(1'b1, 0, 600, 1'b0);
		push_tick(1'b1, 0, -200, 1'b1);
		push_tick(1'b1, 0, -201, 1'b1);
		push_tick(1'b1, 0, 601, 1'b1);
		push_tick(1'b1, 0, 600, 1'b1);
		push_tick(1'b0, 0, 0, 1'b1);
		push_tick(1'b1, 0, 0, 1'b1);

		// manual on, frozen sensors, manual off with gas raising the alarm again
		wait_idle();
		set_config(500, 600, 0, 1);
		push_tick(1'b0, 0, 0, 1'b1);
		push_tick(1'b0, 0, 0, 1'b1);
		repeat (3) push_tick(1'b0, 900, 500, 1'b1);
		repeat (2) push_tick(1'b1, 0, 0, 1'b1);
		repeat (2) push_tick(1'b0, 900, 0, 1'b1);
		repeat (2) push_tick(1'b1, 0, 0, 1'b1);

		run_phase(300, 250, 3, 4, 300);
		run_phase(0, -200, 0, 1, 300);
		wait_idle();
		steady <= 1'b1;
		run_phase($urandom_range(1023), int'($urandom_range(800)) - 200,
			$urandom_range(12), $urandom_range(1, 12), 300);
		wait_idle();
		steady <= 1'b0;
		run_phase(1023, 600, 10000, 10000, 150);
		run_phase(400, 400, 50, 200, 300);
		run_phase($urandom_range(1023), int'($urandom_range(800)) - 200,
			$urandom_range(12), $urandom_range(1, 12), 300);

		// quiet run with a long blink period, then a manual alarm switched on and off again
		wait_idle();
		set_config(1023, 600, 2, 10000);
		repeat (100) push_random_tick(1'b1);
		repeat (6) push_random_tick(1'b0);
		repeat (4) push_random_tick(1'b1);
		repeat (4) push_random_tick(1'b0);
		repeat (4) push_random_tick(1'b1);

		wait_idle();
		repeat (4) @(posedge clk);
		if (due_outputs.size() != 0)
			fault_count = fault_count + 1;
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
